[hdl/cbs_pkg.sv]
// Package for the checksummed byte store.
// Holds widths, command and state codes, the store write request and the checksum fold.
// No dependencies.
package cbs_pkg;

  localparam int unsigned ADDR_W          = 16;
  localparam int unsigned DATA_W          = 8;
  localparam int unsigned PROG_W          = 2;
  localparam int unsigned STORE_BYTES_DEF = 1024;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_BLK_WR = 2'd2,
    CMD_BLK_RD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  // rotate left by one, then add the byte
  function automatic logic [DATA_W-1:0] fold(input logic [DATA_W-1:0] sum,
                                             input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] rot;
    rot  = {sum[DATA_W-2:0], sum[DATA_W-1]};
    fold = rot + b;
  endfunction

endpackage

[hdl/cbs_if.sv]
// Valid/ready channel interfaces for the checksummed byte store.
// Depends on cbs_pkg for field widths.
interface cbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [cbs_pkg::ADDR_W-1:0]    addr;
  logic [cbs_pkg::DATA_W-1:0]    wdata;
  logic                          first;
  logic                          last;

  modport source (output valid, output cmd, output addr, output wdata, output first,
                  output last, input ready);
  modport sink   (input valid, input cmd, input addr, input wdata, input first,
                  input last, output ready);
endinterface

interface cbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [cbs_pkg::DATA_W-1:0]    rdata;
  logic                          checksum_ok;
  logic [cbs_pkg::PROG_W-1:0]    bytes_programmed;

  modport source (output valid, output rdata, output checksum_ok,
                  output bytes_programmed, input ready);
  modport sink   (input valid, input rdata, input checksum_ok,
                  input bytes_programmed, output ready);
endinterface

[hdl/cbs_store.sv]
// Byte store memory: one write port, one registered read port, and a zero
// sweep over every entry after reset. Depends on cbs_pkg.
module cbs_store #(
  parameter int unsigned STORE_BYTES = cbs_pkg::STORE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cbs_pkg::ADDR_W-1:0] rd_addr,
  output logic [cbs_pkg::DATA_W-1:0] rd_data,
  input  cbs_pkg::wr_req_t           wr_req,
  output logic                       busy
);

  localparam int unsigned IDX_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_BYTES - 1);

  logic [cbs_pkg::DATA_W-1:0] mem [STORE_BYTES];
  logic [IDX_W-1:0]           clr_r;
  logic                       busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      clr_r <= clr_r + IDX_W'(1);
      if (clr_r == LAST_IDX) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= '0;
    end else if (wr_req.en) begin
      mem[wr_req.addr[IDX_W-1:0]] <= wr_req.data;
    end
    rd_data <= mem[rd_addr[IDX_W-1:0]];
  end

  assign busy = busy_r;

endmodule

[hdl/checksummed_byte_store_top.sv]
// Checksummed byte store: single reads/writes and checksummed block transfers.
// Results: each result is registered to the output from ST_ACCESS, or from ST_CHECK for the
// last block item; a stalled output holds the state. One item at a time: a new transfer is
// taken only in ST_IDLE; the store's single read port reads the data, then the checksum byte.
// Reset: synchronous; the store is then zeroed in a sweep over every entry, in_ch.ready low.
module checksummed_byte_store_top #(
  parameter int unsigned STORE_BYTES = cbs_pkg::STORE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cbs_in_if.sink    in_ch,
  cbs_out_if.source out_ch
);

  localparam int unsigned AW = cbs_pkg::ADDR_W;
  localparam int unsigned DW = cbs_pkg::DATA_W;
  localparam int unsigned PW = cbs_pkg::PROG_W;
  localparam logic [AW:0] LIMIT = (AW + 1)'(STORE_BYTES);

  cbs_pkg::state_t  state_r, state_nxt;
  cbs_pkg::cmd_t    cmd_r, cmd_in;
  logic             last_r;
  logic [DW-1:0]    wdata_r;
  logic [AW-1:0]    addr_r;
  logic [DW-1:0]    sum_r, sum_nxt;
  logic [AW-1:0]    naddr_r;
  logic [DW-1:0]    rd_r;
  logic             prog_r;

  logic             out_valid_r;
  logic [DW-1:0]    out_rdata_r;
  logic             out_ok_r;
  logic [PW-1:0]    out_prog_r;

  logic [DW-1:0]    q;
  logic             busy;
  logic [AW-1:0]    rd_addr;
  cbs_pkg::wr_req_t wr_req;

  logic             accept, blk_in, blk_r, to_check, out_free, advance, blk_step;
  logic [AW-1:0]    eff_addr, ck_addr;
  logic             rng_a, rng_c, chg_a, chg_c;
  logic [DW-1:0]    byte_a, byte_c;
  logic             do_out;
  logic [DW-1:0]    res_rdata;
  logic             res_ok;
  logic [PW-1:0]    res_prog;

  cbs_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (q),
    .wr_req  (wr_req),
    .busy    (busy)
  );

  assign cmd_in   = cbs_pkg::cmd_t'(in_ch.cmd);
  assign blk_in   = (cmd_in == cbs_pkg::CMD_BLK_WR) || (cmd_in == cbs_pkg::CMD_BLK_RD);
  assign eff_addr = (blk_in && !in_ch.first) ? naddr_r : in_ch.addr;
  assign in_ch.ready = (state_r == cbs_pkg::ST_IDLE) && !busy;
  assign accept   = in_ch.valid && in_ch.ready;

  assign blk_r    = (cmd_r == cbs_pkg::CMD_BLK_WR) || (cmd_r == cbs_pkg::CMD_BLK_RD);
  assign to_check = blk_r && last_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = to_check || out_free;
  assign blk_step = (state_r == cbs_pkg::ST_ACCESS) && advance && blk_r;

  assign ck_addr  = addr_r + AW'(1);
  assign rng_a    = {1'b0, addr_r} < LIMIT;
  assign rng_c    = {1'b0, ck_addr} < LIMIT;
  assign byte_a   = rng_a ? q : '0;
  assign byte_c   = rng_c ? q : '0;
  assign chg_a    = rng_a && (q != wdata_r);
  assign chg_c    = rng_c && (q != sum_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbs_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = cbs_pkg::ST_ACCESS;
        end
      end
      cbs_pkg::ST_ACCESS: begin
        if (to_check) begin
          state_nxt = cbs_pkg::ST_CHECK;
        end else if (out_free) begin
          state_nxt = cbs_pkg::ST_IDLE;
        end
      end
      cbs_pkg::ST_CHECK: begin
        if (out_free) begin
          state_nxt = cbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr     = addr_r;
    wr_req.en   = 1'b0;
    wr_req.addr = addr_r;
    wr_req.data = wdata_r;
    do_out      = 1'b0;
    res_rdata   = '0;
    res_ok      = 1'b0;
    res_prog    = '0;
    sum_nxt     = sum_r;
    case (state_r)
      cbs_pkg::ST_IDLE: begin
        rd_addr = eff_addr;
      end
      cbs_pkg::ST_ACCESS: begin
        // fetch the checksum byte next when this is the end of a block
        if (to_check) begin
          rd_addr = ck_addr;
        end
        if (advance) begin
          case (cmd_r)
            cbs_pkg::CMD_READ: begin
              res_rdata = byte_a;
              do_out    = 1'b1;
            end
            cbs_pkg::CMD_WRITE: begin
              wr_req.en = chg_a;
              res_prog  = PW'(chg_a);
              do_out    = 1'b1;
            end
            cbs_pkg::CMD_BLK_WR: begin
              wr_req.en = chg_a;
              sum_nxt   = cbs_pkg::fold(sum_r, wdata_r);
              res_prog  = PW'(chg_a);
              do_out    = !last_r;
            end
            cbs_pkg::CMD_BLK_RD: begin
              res_rdata = byte_a;
              sum_nxt   = cbs_pkg::fold(sum_r, byte_a);
              do_out    = !last_r;
            end
            default: do_out = 1'b0;
          endcase
        end
      end
      cbs_pkg::ST_CHECK: begin
        rd_addr = ck_addr;
        if (out_free) begin
          do_out = 1'b1;
          case (cmd_r)
            cbs_pkg::CMD_BLK_WR: begin
              wr_req.en   = chg_c;
              wr_req.addr = ck_addr;
              wr_req.data = sum_r;
              res_prog    = PW'(prog_r) + PW'(chg_c);
            end
            cbs_pkg::CMD_BLK_RD: begin
              res_rdata = rd_r;
              res_ok    = (byte_c == sum_r);
            end
            default: res_ok = 1'b0;
          endcase
        end
      end
      default: rd_addr = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbs_pkg::ST_IDLE;
      sum_r       <= '0;
      naddr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && blk_in && in_ch.first) begin
        sum_r <= '0;
      end else if (blk_step) begin
        sum_r   <= sum_nxt;
        naddr_r <= ck_addr;
      end
      if (do_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_in;
      last_r  <= in_ch.last;
      wdata_r <= in_ch.wdata;
      addr_r  <= eff_addr;
    end
    if (blk_step) begin
      rd_r   <= byte_a;
      prog_r <= chg_a && (cmd_r == cbs_pkg::CMD_BLK_WR);
    end
    if (do_out) begin
      out_rdata_r <= res_rdata;
      out_ok_r    <= res_ok;
      out_prog_r  <= res_prog;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.rdata            = out_rdata_r;
  assign out_ch.checksum_ok      = out_ok_r;
  assign out_ch.bytes_programmed = out_prog_r;

endmodule

[hdl/cbs_checker.sv]
// Port-level checks for the checksummed byte store, bound to the top level.
// Depends on cbs_pkg and checksummed_byte_store_top.
module cbs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cbs_pkg::PROG_W-1:0] out_bytes_programmed
);

  // the zero sweep keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // one item in the store pipeline at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken before the first finished");

  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes_programmed != 2'd3)
    else $error("more than two bytes programmed by one item");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bytes_programmed))
    else $error("stalled result dropped or changed");

endmodule

bind checksummed_byte_store_top cbs_checker u_cbs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_bytes_programmed (out_ch.bytes_programmed)
);
